// File: rtl/per_core_page_allocator_with_steal_assert.svh
// Assertion macros used by the checker file.
`ifndef PER_CORE_PAGE_ALLOCATOR_WITH_STEAL_ASSERT_SVH
`define PER_CORE_PAGE_ALLOCATOR_WITH_STEAL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pcpa_pkg.sv
`default_nettype none
package pcpa_pkg;

   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_NUM_W = 20;
   localparam int LIMIT_W    = 21;
   localparam int ADDR_W     = 32;
   localparam int CORE_IN_W  = 3;
   localparam int TDATA_W    = 40;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

   localparam logic REG_FIRST_PAGE = 1'b0;
   localparam logic REG_LIMIT_PAGE = 1'b1;

   localparam logic [PAGE_NUM_W-1:0] FIRST_PAGE_RST = 20'd524288;
   localparam logic [LIMIT_W-1:0]    LIMIT_PAGE_RST = 21'd557056;

   typedef struct packed {
      logic [PAGE_NUM_W-1:0] first_page;
      logic [LIMIT_W-1:0]    limit_page;
   } pcpa_cfg_type;

   // Decoded request; slot is the page number minus first_page.
   typedef struct packed {
      logic                  cmd;
      logic [CORE_IN_W-1:0]  core;
      logic [PAGE_NUM_W-1:0] slot;
      logic                  bad;
   } pcpa_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] page_addr;
   } pcpa_rsp_type;

endpackage
`default_nettype wire

// File: rtl/pcpa_csr.sv
`default_nettype none
module pcpa_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [pcpa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [pcpa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pcpa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output pcpa_pkg::pcpa_cfg_type              cfg
);

   logic [pcpa_pkg::PAGE_NUM_W-1:0] first_page_ff;
   logic [pcpa_pkg::LIMIT_W-1:0]    limit_page_ff;
   logic                            reg_sel;
   logic                            wr_en;

   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= pcpa_pkg::FIRST_PAGE_RST;
         limit_page_ff <= pcpa_pkg::LIMIT_PAGE_RST;
      end else if (wr_en) begin
         case (reg_sel)
            pcpa_pkg::REG_FIRST_PAGE: begin
               first_page_ff <= csr_pwdata[pcpa_pkg::PAGE_NUM_W-1:0];
            end
            pcpa_pkg::REG_LIMIT_PAGE: begin
               limit_page_ff <= csr_pwdata[pcpa_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         pcpa_pkg::REG_FIRST_PAGE: csr_prdata = pcpa_pkg::CSR_DATA_W'(first_page_ff);
         pcpa_pkg::REG_LIMIT_PAGE: csr_prdata = pcpa_pkg::CSR_DATA_W'(limit_page_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   assign cfg.first_page = first_page_ff;
   assign cfg.limit_page = limit_page_ff;

endmodule
`default_nettype wire

// File: rtl/pcpa_engine.sv
`default_nettype none
module pcpa_engine #(
   parameter int NUM_CORES = 8,
   parameter int NUM_PAGES = 32768
) (
   input  wire                     clock,
   input  wire                     reset,
   input  pcpa_pkg::pcpa_cfg_type  cfg,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  pcpa_pkg::pcpa_req_type  req,
   output logic                    res_valid,
   input  wire                     res_ready,
   output pcpa_pkg::pcpa_rsp_type  res
);

   localparam int SLOT_W = $clog2(NUM_PAGES);
   localparam int LINK_W = SLOT_W + 1;
   localparam int CORE_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam logic [SLOT_W-1:0] STEP_LAST = SLOT_W'(NUM_PAGES - 1);
   localparam logic [SLOT_W-1:0] STEP_ONE  = SLOT_W'(1);
   localparam logic [LINK_W-1:0] LINK_ONE  = LINK_W'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FREE,
      ST_ALLOC,
      ST_POP,
      ST_STEAL,
      ST_WALK_N1,
      ST_WALK_N2,
      ST_WALK_SLOW,
      ST_CUT,
      ST_RELOAD
   } state_type;

   // Link memory holds slot+1 of the next page, zero at the end of a list.
   logic [LINK_W-1:0] link_mem [NUM_PAGES];
   logic [SLOT_W-1:0] head_mem [NUM_CORES];

   logic              link_we;
   logic [SLOT_W-1:0] link_waddr;
   logic [LINK_W-1:0] link_wdata;
   logic              link_re;
   logic [SLOT_W-1:0] link_raddr;
   logic [LINK_W-1:0] link_rd_ff;

   logic              head_we;
   logic [CORE_W-1:0] head_waddr;
   logic [SLOT_W-1:0] head_wdata;
   logic              head_re;
   logic [CORE_W-1:0] head_raddr;
   logic [SLOT_W-1:0] head_rd_ff;

   state_type              state_ff, state_in;
   logic [NUM_CORES-1:0]   nonempty_ff, nonempty_in;
   logic [CORE_W-1:0]      core_ff, core_in;
   logic [CORE_W-1:0]      victim_ff, victim_in;
   logic                   bad_ff, bad_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SLOT_W-1:0]      pop_ff, pop_in;
   logic [SLOT_W-1:0]      slow_ff, slow_in;
   logic [LINK_W-1:0]      n2_ff, n2_in;
   logic [SLOT_W-1:0]      steps_ff, steps_in;

   logic [NUM_CORES-1:0]             cand;
   logic                             found;
   logic [CORE_W-1:0]                vic;
   logic [LINK_W-1:0]                link_dec;
   logic [LINK_W-1:0]                n2_dec;
   logic [pcpa_pkg::PAGE_NUM_W-1:0]  page_num;
   logic [CORE_W-1:0]                req_core;

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      if (head_re) begin
         head_rd_ff <= head_mem[head_raddr];
      end
   end

   assign req_core = CORE_W'(req.core);
   assign link_dec = link_rd_ff - LINK_ONE;
   assign n2_dec   = n2_ff - LINK_ONE;
   assign page_num = cfg.first_page + pcpa_pkg::PAGE_NUM_W'(pop_ff);

   // Lowest-numbered non-empty list other than the requester's own.
   always_comb begin
      cand          = nonempty_ff;
      cand[core_ff] = 1'b0;
      found         = 1'b0;
      vic           = '0;
      for (int i = NUM_CORES - 1; i >= 0; i--) begin
         if (cand[i]) begin
            found = 1'b1;
            vic   = CORE_W'(i);
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      nonempty_in = nonempty_ff;
      core_in     = core_ff;
      victim_in   = victim_ff;
      bad_in      = bad_ff;
      slot_in     = slot_ff;
      pop_in      = pop_ff;
      slow_in     = slow_ff;
      n2_in       = n2_ff;
      steps_in    = steps_ff;

      link_we    = 1'b0;
      link_waddr = slot_ff;
      link_wdata = '0;
      link_re    = 1'b0;
      link_raddr = slow_ff;
      head_we    = 1'b0;
      head_waddr = core_ff;
      head_wdata = slot_ff;
      head_re    = 1'b0;
      head_raddr = core_ff;

      req_ready     = 1'b0;
      res_valid     = 1'b0;
      res.status    = pcpa_pkg::STATUS_OK;
      res.page_addr = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               core_in    = req_core;
               bad_in     = req.bad;
               slot_in    = req.slot[SLOT_W-1:0];
               head_re    = 1'b1;
               head_raddr = req_core;
               state_in   = (req.cmd == pcpa_pkg::CMD_FREE) ? ST_FREE : ST_ALLOC;
            end
         end
         ST_FREE: begin
            if (res_ready) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
               if (bad_ff) begin
                  res.status = pcpa_pkg::STATUS_BAD_ADDR;
               end else begin
                  link_we              = 1'b1;
                  link_waddr           = slot_ff;
                  link_wdata           = nonempty_ff[core_ff] ?
                                         LINK_W'(head_rd_ff) + LINK_ONE : '0;
                  head_we              = 1'b1;
                  head_waddr           = core_ff;
                  head_wdata           = slot_ff;
                  nonempty_in[core_ff] = 1'b1;
               end
            end
         end
         ST_ALLOC: begin
            if (nonempty_ff[core_ff]) begin
               pop_in     = head_rd_ff;
               link_re    = 1'b1;
               link_raddr = head_rd_ff;
               state_in   = ST_POP;
            end else if (found) begin
               victim_in  = vic;
               head_re    = 1'b1;
               head_raddr = vic;
               state_in   = ST_STEAL;
            end else if (res_ready) begin
               res_valid  = 1'b1;
               res.status = pcpa_pkg::STATUS_EMPTY;
               state_in   = ST_IDLE;
            end
         end
         ST_POP: begin
            if (res_ready) begin
               res_valid     = 1'b1;
               res.page_addr = {page_num, pcpa_pkg::PAGE_SHIFT'(0)};
               state_in      = ST_IDLE;
               if (link_rd_ff != '0) begin
                  head_we    = 1'b1;
                  head_waddr = core_ff;
                  head_wdata = link_dec[SLOT_W-1:0];
               end else begin
                  nonempty_in[core_ff] = 1'b0;
               end
            end
         end
         ST_STEAL: begin
            // The victim's head becomes the local head after the split.
            pop_in     = head_rd_ff;
            slow_in    = head_rd_ff;
            steps_in   = '0;
            link_re    = 1'b1;
            link_raddr = head_rd_ff;
            state_in   = ST_WALK_N1;
         end
         ST_WALK_N1: begin
            link_re = 1'b1;
            if (link_rd_ff == '0) begin
               link_raddr = slow_ff;
               state_in   = ST_CUT;
            end else begin
               link_raddr = link_dec[SLOT_W-1:0];
               state_in   = ST_WALK_N2;
            end
         end
         ST_WALK_N2: begin
            link_re    = 1'b1;
            link_raddr = slow_ff;
            n2_in      = link_rd_ff;
            state_in   = (link_rd_ff == '0) ? ST_CUT : ST_WALK_SLOW;
         end
         ST_WALK_SLOW: begin
            link_re = 1'b1;
            if (link_rd_ff == '0) begin
               link_raddr = slow_ff;
               state_in   = ST_CUT;
            end else begin
               slow_in  = link_dec[SLOT_W-1:0];
               steps_in = steps_ff + STEP_ONE;
               // The walk is bounded so that a corrupted, cyclic list ends.
               if (steps_ff == STEP_LAST) begin
                  link_raddr = link_dec[SLOT_W-1:0];
                  state_in   = ST_CUT;
               end else begin
                  link_raddr = n2_dec[SLOT_W-1:0];
                  state_in   = ST_WALK_N1;
               end
            end
         end
         ST_CUT: begin
            if (link_rd_ff != '0) begin
               head_we    = 1'b1;
               head_waddr = victim_ff;
               head_wdata = link_dec[SLOT_W-1:0];
            end else begin
               nonempty_in[victim_ff] = 1'b0;
            end
            link_we              = 1'b1;
            link_waddr           = slow_ff;
            link_wdata           = '0;
            nonempty_in[core_ff] = 1'b1;
            state_in             = ST_RELOAD;
         end
         ST_RELOAD: begin
            // Read after the cut so that a one-page steal sees the cleared link.
            link_re    = 1'b1;
            link_raddr = pop_ff;
            state_in   = ST_POP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      core_ff   <= core_in;
      victim_ff <= victim_in;
      bad_ff    <= bad_in;
      slot_ff   <= slot_in;
      pop_ff    <= pop_in;
      slow_ff   <= slow_in;
      n2_ff     <= n2_in;
      steps_ff  <= steps_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         nonempty_ff <= '0;
      end else begin
         state_ff    <= state_in;
         nonempty_ff <= nonempty_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/per_core_page_allocator_with_steal.sv
`default_nettype none
// Channel   Direction  Payload
// req_*     in         tdata: cmd, core, addr
// rsp_*     out        tdata: status, page_addr
// csr_*     in/out     first_page at 0x0, limit_page at 0x4
//
// A steal from a victim list walks that list to find where to split it: each walk step
// makes three reads on the one link-memory port.
// Reset is synchronous; lists start empty and the link memory needs no clearing.
// A result waits in the output register while the next request is worked on; a
// request stalls in its last cycle while that register is still full.
module per_core_page_allocator_with_steal #(
   parameter int NUM_CORES = 8,
   parameter int NUM_PAGES = 32768
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [pcpa_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [pcpa_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [pcpa_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // [0] cmd, [3:1] core, [35:4] addr, [39:36] zero
   input  wire  [pcpa_pkg::TDATA_W-1:0]        req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [1:0] status, [33:2] page_addr, [39:34] zero
   output logic [pcpa_pkg::TDATA_W-1:0]        rsp_tdata
);

   localparam logic [6:0]                   CORES_7 = 7'(NUM_CORES);
   localparam logic [pcpa_pkg::LIMIT_W-1:0] PAGES_L = pcpa_pkg::LIMIT_W'(NUM_PAGES);

   pcpa_pkg::pcpa_cfg_type cfg;
   pcpa_pkg::pcpa_req_type req;
   pcpa_pkg::pcpa_rsp_type res;
   pcpa_pkg::pcpa_rsp_type rsp_data_ff;
   logic                   rsp_valid_ff;
   logic                   res_valid;
   logic                   res_ready;

   logic [pcpa_pkg::ADDR_W-1:0]     addr;
   logic [pcpa_pkg::PAGE_NUM_W-1:0] page;
   logic [pcpa_pkg::PAGE_NUM_W-1:0] page_off;
   logic                            misaligned;
   logic                            below;
   logic                            above;
   logic                            beyond;

   function automatic logic [2:0] core_wrap(input logic [2:0] raw);
      logic [6:0] t;
      t = 7'(raw);
      for (int i = 0; i < 8; i++) begin
         if (t >= CORES_7) begin
            t = t - CORES_7;
         end
      end
      return t[2:0];
   endfunction

   pcpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign addr       = req_tdata[35:4];
   assign page       = addr[pcpa_pkg::ADDR_W-1:pcpa_pkg::PAGE_SHIFT];
   assign misaligned = addr[pcpa_pkg::PAGE_SHIFT-1:0] != '0;
   assign below      = page < cfg.first_page;
   assign above      = pcpa_pkg::LIMIT_W'(page) >= cfg.limit_page;
   assign page_off   = page - cfg.first_page;
   assign beyond     = pcpa_pkg::LIMIT_W'(page_off) >= PAGES_L;

   assign req.cmd  = req_tdata[0];
   assign req.core = core_wrap(req_tdata[3:1]);
   assign req.slot = page_off;
   assign req.bad  = misaligned || below || above || beyond;

   pcpa_engine #(
      .NUM_CORES (NUM_CORES),
      .NUM_PAGES (NUM_PAGES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.page_addr, rsp_data_ff.status};

endmodule
`default_nettype wire

// File: rtl/pcpa_checker.sv
`default_nettype none
`include "per_core_page_allocator_with_steal_assert.svh"
module pcpa_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_tvalid,
   input wire                           req_tready,
   input wire                           rsp_tvalid,
   input wire                           rsp_tready,
   input wire [pcpa_pkg::TDATA_W-1:0]   rsp_tdata
);

   logic [1:0]  status;
   logic [31:0] page_addr;

   assign status    = rsp_tdata[1:0];
   assign page_addr = rsp_tdata[33:2];

   `PCPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `PCPA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")
   `PCPA_ASSERT_NOW(a_status_legal, clock, reset, rsp_tvalid, status == pcpa_pkg::STATUS_OK || status == pcpa_pkg::STATUS_EMPTY || status == pcpa_pkg::STATUS_BAD_ADDR, "illegal status code")
   `PCPA_ASSERT_NOW(a_fail_no_addr, clock, reset, rsp_tvalid && status != pcpa_pkg::STATUS_OK, page_addr == '0, "address on a failed request")
   `PCPA_ASSERT_NOW(a_page_aligned, clock, reset, rsp_tvalid, rsp_tdata[13:2] == '0 && rsp_tdata[39:34] == '0, "unaligned page or padding set")

endmodule

bind per_core_page_allocator_with_steal pcpa_checker u_pcpa_checker (.*);
`default_nettype wire

// File: tb/tb_per_core_page_allocator_with_steal.sv
`default_nettype none
module tb_per_core_page_allocator_with_steal;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CORES = 8;
   localparam int NUM_PAGES = 32768;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] page_addr;
   } page_result_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [pcpa_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [pcpa_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [pcpa_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // [0] cmd, [3:1] core, [35:4] addr, [39:36] zero
   logic [pcpa_pkg::TDATA_W-1:0]    req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // [1:0] status, [33:2] page_addr, [39:34] zero
   logic [pcpa_pkg::TDATA_W-1:0]    rsp_tdata;

   per_core_page_allocator_with_steal #(
      .NUM_CORES(NUM_CORES),
      .NUM_PAGES(NUM_PAGES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Allocator state as the testbench sees it.
   logic [pcpa_pkg::PAGE_NUM_W-1:0] cfg_first = pcpa_pkg::FIRST_PAGE_RST;
   logic [pcpa_pkg::LIMIT_W-1:0]    cfg_limit = pcpa_pkg::LIMIT_PAGE_RST;
   logic [14:0]           head_slot [NUM_CORES];
   bit                    has_pages [NUM_CORES];
   // Each entry holds the successor's slot plus one; zero ends a list.
   logic [15:0]           link_mem [NUM_PAGES];
   bit                    slot_listed [NUM_PAGES];

   page_result_type page_result_q[$];
   int error_count = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic void report_mismatch(input string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endfunction

   function automatic void decode_free_addr(input logic [31:0] addr, output bit ok,
                                            output logic [14:0] slot);
      logic [19:0] page;
      page = addr[31:12];
      ok = (addr[11:0] == 12'd0) && (page >= cfg_first) && (page < cfg_limit) &&
           ((page - cfg_first) < NUM_PAGES);
      slot = 15'(page - cfg_first);
   endfunction

   function automatic page_result_type predict_page_op(input logic cmd,
                                                       input logic [2:0] core,
                                                       input logic [31:0] addr);
      page_result_type res;
      bit ok;
      logic [14:0] slot, slow, fast, s;
      logic [15:0] n1, n2, nx;
      int c;
      res.status = pcpa_pkg::STATUS_OK;
      res.page_addr = 32'd0;
      c = int'(core) % NUM_CORES;
      if (cmd == pcpa_pkg::CMD_FREE) begin
         decode_free_addr(addr, ok, slot);
         if (!ok) begin
            res.status = pcpa_pkg::STATUS_BAD_ADDR;
            return res;
         end
         link_mem[slot] = has_pages[c] ? 16'(head_slot[c]) + 16'd1 : 16'd0;
         head_slot[c] = slot;
         has_pages[c] = 1'b1;
         slot_listed[slot] = 1'b1;
         return res;
      end
      if (!has_pages[c]) begin
         // Scan the other cores in ascending order and take the front half of the first
         // non-empty list; the walk is bounded so a cycle left by a double free ends.
         for (int v = 0; v < NUM_CORES; v++) begin
            if (v == c || !has_pages[v]) continue;
            slow = head_slot[v];
            fast = slow;
            for (int step = 0; step < NUM_PAGES; step++) begin
               n1 = link_mem[fast];
               if (n1 == 16'd0) break;
               n2 = link_mem[15'(n1 - 16'd1)];
               if (n2 == 16'd0 || link_mem[slow] == 16'd0) break;
               slow = 15'(link_mem[slow] - 16'd1);
               fast = 15'(n2 - 16'd1);
            end
            head_slot[c] = head_slot[v];
            has_pages[c] = 1'b1;
            nx = link_mem[slow];
            if (nx != 16'd0) head_slot[v] = 15'(nx - 16'd1);
            else has_pages[v] = 1'b0;
            link_mem[slow] = 16'd0;
            break;
         end
         if (!has_pages[c]) begin
            res.status = pcpa_pkg::STATUS_EMPTY;
            return res;
         end
      end
      s = head_slot[c];
      nx = link_mem[s];
      if (nx != 16'd0) head_slot[c] = 15'(nx - 16'd1);
      else has_pages[c] = 1'b0;
      slot_listed[s] = 1'b0;
      res.page_addr = (32'(cfg_first) + 32'(s)) << pcpa_pkg::PAGE_SHIFT;
      return res;
   endfunction

   // Returns just after the rising edge that completes the transfer; valid stays high so
   // that a following item can go out without a gap.
   task automatic issue_page_op(input logic cmd, input logic [2:0] core,
                                input logic [31:0] addr);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, addr, core, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      page_result_q.push_back(predict_page_op(cmd, core, addr));
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (page_result_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == pcpa_pkg::REG_FIRST_PAGE) cfg_first = value[pcpa_pkg::PAGE_NUM_W-1:0];
      else cfg_limit = value[pcpa_pkg::LIMIT_W-1:0];
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_read(input logic idx);
      logic [31:0] want;
      want = (idx == pcpa_pkg::REG_FIRST_PAGE) ? 32'(cfg_first) : 32'(cfg_limit);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want)
         report_mismatch($sformatf("register %0d read: expected %h, got %h",
                                   idx, want, csr_prdata));
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_window(input logic [19:0] first, input logic [20:0] limit);
      quiesce();
      csr_write(pcpa_pkg::REG_FIRST_PAGE, 32'(first));
      csr_write(pcpa_pkg::REG_LIMIT_PAGE, 32'(limit));
      csr_read(pcpa_pkg::REG_FIRST_PAGE);
      csr_read(pcpa_pkg::REG_LIMIT_PAGE);
   endtask

   task automatic drain_lists();
      int guard;
      guard = 0;
      for (int c = 0; c < NUM_CORES; c++) begin
         while (has_pages[c] && guard < 40000) begin
            issue_page_op(pcpa_pkg::CMD_ALLOC, 3'(c), $urandom);
            guard++;
         end
      end
   endtask

   function automatic logic [31:0] slot_addr(input int slot);
      return (32'(cfg_first) + 32'(slot)) << pcpa_pkg::PAGE_SHIFT;
   endfunction

   always @(posedge clock) begin : rsp_check
      page_result_type want;
      logic [1:0]  got_status;
      logic [31:0] got_addr;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = rsp_tdata[1:0];
         got_addr = rsp_tdata[33:2];
         if (page_result_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result: status %0d page_addr %h",
                                      got_status, got_addr));
         end else begin
            want = page_result_q.pop_front();
            if (got_status !== want.status || got_addr !== want.page_addr)
               report_mismatch($sformatf(
                  "result mismatch: expected status %0d page_addr %h, got status %0d page_addr %h",
                  want.status, want.page_addr, got_status, got_addr));
         end
      end
   end

   // Field extremes, misaligned, below-window and above-limit free addresses, and local pushes and pops.
   task automatic test_free_alloc_edges();
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd0, 32'd0);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd0, slot_addr(0));
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd7,
                    32'(cfg_limit - 21'd1) << pcpa_pkg::PAGE_SHIFT);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd7, 32'(cfg_limit) << pcpa_pkg::PAGE_SHIFT);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd0,
                    32'(cfg_first - 20'd1) << pcpa_pkg::PAGE_SHIFT);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd0, slot_addr(1) | 32'd1);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd0, slot_addr(1) | 32'h800);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd0, 32'hFFFF_FFFF);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd0, 32'd0);
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd7, 32'hFFFF_FFFF);
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd0, 32'd0);
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd0, 32'h5A5A_A5A5);
   endtask

   // Steals take the front half of the lowest-numbered non-empty list.
   task automatic test_steal_order();
      for (int s = 10; s < 15; s++) issue_page_op(pcpa_pkg::CMD_FREE, 3'd3, slot_addr(s));
      repeat (5) issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd5, $urandom);
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd2, $urandom);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd6, slot_addr(20));
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd1, slot_addr(21));
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd1, slot_addr(22));
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd4, $urandom);
      repeat (3) issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd1, $urandom);
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd4, $urandom);
   endtask

   // Listed pages keep their slots when first_page moves, so addresses shift and can wrap.
   task automatic test_config_shift();
      set_window(20'd0, 21'h10_0000);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd2, 32'(32767) << pcpa_pkg::PAGE_SHIFT);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd2, 32'(32768) << pcpa_pkg::PAGE_SHIFT);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd2, 32'd0);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd2, 32'hFFFF_F000);
      set_window(20'hF_FFFF, 21'h10_0000);
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd2, $urandom);
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd2, $urandom);
      set_window(20'hF_FFFF, 21'd0);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd7, 32'hFFFF_F000);
      set_window(20'hF_FFFF, 21'h10_0000);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd7, 32'hFFFF_F000);
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd7, $urandom);
   endtask

   task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
      int r, window, slot, tries;
      bit ok, found;
      logic [14:0] dslot;
      logic [31:0] addr;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         window = int'(cfg_limit) - int'(cfg_first);
         if (window > NUM_PAGES) window = NUM_PAGES;
         r = $urandom_range(99);
         if (r < 45) begin
            // Free a page that is not already on some list.
            found = 1'b0;
            slot = 0;
            for (tries = 0; tries < 8 && window > 0 && !found; tries++) begin
               slot = $urandom_range(window - 1);
               found = !slot_listed[slot];
            end
            if (found) issue_page_op(pcpa_pkg::CMD_FREE, 3'($urandom), slot_addr(slot));
            else issue_page_op(pcpa_pkg::CMD_ALLOC, 3'($urandom), $urandom);
         end else if (r < 88) begin
            issue_page_op(pcpa_pkg::CMD_ALLOC, 3'($urandom), $urandom);
         end else begin
            case ($urandom_range(3))
               0: addr = $urandom;
               1: addr = (window > 0 ? slot_addr($urandom_range(window - 1)) : $urandom) |
                         32'($urandom_range(4095, 1));
               2: addr = (cfg_first != 0) ?
                         32'($urandom_range(int'(cfg_first) - 1)) << pcpa_pkg::PAGE_SHIFT :
                         $urandom;
               default: addr = (cfg_limit < 21'h10_0000) ?
                         32'($urandom_range(32'hF_FFFF, int'(cfg_limit)))
                            << pcpa_pkg::PAGE_SHIFT :
                         $urandom;
            endcase
            // Random noise must not free a page twice.
            decode_free_addr(addr, ok, dslot);
            if (ok && slot_listed[dslot]) addr[0] = 1'b1;
            issue_page_op(pcpa_pkg::CMD_FREE, 3'($urandom), addr);
         end
         if ($urandom_range(99) == 0) quiesce();
      end
   endtask

   // Freeing one page twice links it to itself; a steal from that list must stop at the
   // walk bound and split the loop.
   task automatic test_double_free();
      logic [31:0] addr;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      drain_lists();
      addr = slot_addr(3);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd1, addr);
      issue_page_op(pcpa_pkg::CMD_FREE, 3'd1, addr);
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd1, $urandom);
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd4, $urandom);
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd1, $urandom);
      issue_page_op(pcpa_pkg::CMD_ALLOC, 3'd4, $urandom);
   endtask

   initial begin
      int waited;
      for (int c = 0; c < NUM_CORES; c++) begin
         head_slot[c] = '0;
         has_pages[c] = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_free_alloc_edges();
      test_steal_order();
      test_config_shift();

      set_window(pcpa_pkg::FIRST_PAGE_RST, pcpa_pkg::LIMIT_PAGE_RST);
      run_random_phase(300, 0, 0);
      set_window(20'd0, 21'h10_0000);
      run_random_phase(300, 72, 0);
      set_window(20'h0_0400, 21'h0_0430);
      run_random_phase(300, 0, 72);
      set_window(20'hF_FFF0, 21'h10_0000);
      run_random_phase(300, 38, 38);

      test_double_free();

      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (page_result_q.size() != 0 && waited < 400000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (page_result_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   page_result_q.size()));
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
